// ===== sv/irdf_pkg.sv =====
// Shared types and constants for the link deframer with XOR frame check.
package irdf_pkg;

  // Link tokens
  localparam logic [7:0] TOKEN_START = 8'h23;
  localparam logic [7:0] TOKEN_END   = 8'h25;

  // Reset value of the expected sender id
  localparam logic [7:0] EXP_SENDER_RST = 8'd75;

  // Frame status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERRUN = 2'd1,
    ST_SENDER  = 2'd2,
    ST_CHECK   = 2'd3
  } frame_stat_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_EXP_SENDER = 1'b0,
    CFG_ANY_SENDER = 1'b1
  } cfg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_LOAD = 2'd2
  } irdf_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // input transfer this cycle
    logic load_stat;  // load a status item into the output register
    logic rd_en;      // read the store at the read index
    logic load_byte;  // load the read byte into the output register
  } irdf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic close_stat;   // end token closes a frame with a single status item
    logic close_burst;  // end token closes a valid frame with payload
    logic rd_last;      // read byte is the final payload byte
  } irdf_stat_t;

endpackage

// ===== sv/irdf_dp.sv =====
// Datapath: frame store, running checksum, frame verdict and output register.
module irdf_dp
  import irdf_pkg::*;
#(
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic [7:0]  rx_byte,
  input  irdf_cmd_t   cmd,
  output irdf_stat_t  stat,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic [1:0]  frame_status,
  output logic [7:0]  sender_id,
  output logic        last
);

  localparam int CW = $clog2(FRAME_BYTES);
  localparam logic [CW-1:0] CNT_MAX = CW'(FRAME_BYTES - 1);

  // Configuration
  logic [7:0] exp_sender_r;
  logic       any_sender_r;

  // Frame tracking
  logic          in_frame_r, in_frame_nxt;
  logic          ovr_r, ovr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    sender_r;
  logic [7:0]    xacc_r;
  logic [7:0]    b1_r, b2_r;   // last and second to last stored bytes

  // Store and read-out
  logic [7:0]    frame_mem_r [FRAME_BYTES];
  logic [7:0]    rd_q_r;
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] last_idx_r;

  // Output register
  logic [7:0] out_data_r;
  logic       out_bv_r;
  logic [1:0] out_st_r;
  logic [7:0] out_snd_r;
  logic       out_last_r;

  // Byte decode
  logic is_start, is_end, is_data, store_en;
  logic end_hit;
  logic [7:0] v_sender;
  logic [7:0] v_sum;
  logic [7:0] v_ref;
  frame_stat_t v_status;
  logic v_burst;

  assign is_start = (rx_byte == TOKEN_START);
  assign is_end   = (rx_byte == TOKEN_END);
  assign is_data  = (rx_byte != 8'd0) && !is_start && !is_end && in_frame_r;
  assign store_en = cmd.accept && is_data && !ovr_r && (cnt_r != CNT_MAX);
  assign end_hit  = is_end && in_frame_r;

  // Frame verdict from the registered frame state
  assign v_sender = (cnt_r != '0) ? sender_r : 8'd0;
  assign v_sum    = xacc_r ^ b1_r ^ b2_r;
  assign v_ref    = {b1_r[3:0], b2_r[3:0]};

  always_comb begin
    v_burst = 1'b0;
    if (ovr_r) begin
      v_status = ST_OVERRUN;
    end else if (!any_sender_r && (v_sender != exp_sender_r)) begin
      v_status = ST_SENDER;
    end else if (cnt_r < CW'(3)) begin
      v_status = ST_CHECK;
    end else if (v_sum != v_ref) begin
      v_status = ST_CHECK;
    end else begin
      v_status = ST_OK;
      v_burst  = (cnt_r != CW'(3));
    end
  end

  assign stat.close_burst = end_hit && v_burst;
  assign stat.close_stat  = end_hit && !v_burst;
  assign stat.rd_last     = (rd_idx_r == last_idx_r);

  // Frame state next values
  always_comb begin
    in_frame_nxt = in_frame_r;
    ovr_nxt      = ovr_r;
    cnt_nxt      = cnt_r;
    if (cmd.accept && (rx_byte != 8'd0)) begin
      if (is_start) begin
        in_frame_nxt = 1'b1;
        ovr_nxt      = 1'b0;
        cnt_nxt      = '0;
      end else if (end_hit) begin
        in_frame_nxt = 1'b0;
      end else if (is_data && !ovr_r) begin
        if (cnt_r != CNT_MAX) begin
          cnt_nxt = cnt_r + CW'(1);
        end else begin
          ovr_nxt = 1'b1;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_sender_r <= EXP_SENDER_RST;
      any_sender_r <= 1'b0;
      in_frame_r   <= 1'b0;
      ovr_r        <= 1'b0;
      cnt_r        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_EXP_SENDER: exp_sender_r <= cfg_wdata;
          CFG_ANY_SENDER: any_sender_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      in_frame_r <= in_frame_nxt;
      ovr_r      <= ovr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Sender id, running XOR over bytes after the id, last two bytes
  always_ff @(posedge clk) begin
    if (cmd.accept && is_start) begin
      xacc_r <= 8'd0;
    end else if (store_en) begin
      if (cnt_r == '0) begin
        sender_r <= rx_byte;
      end else begin
        xacc_r <= xacc_r ^ rx_byte;
      end
      b2_r <= b1_r;
      b1_r <= rx_byte;
    end
  end

  // Frame store: one write port, registered read
  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_mem_r[cnt_r] <= rx_byte;
    end
    if (cmd.rd_en) begin
      rd_q_r <= frame_mem_r[rd_idx_r];
    end
  end

  // Read index runs from the first payload byte to the last
  always_ff @(posedge clk) begin
    if (cmd.accept && stat.close_burst) begin
      rd_idx_r   <= CW'(1);
      last_idx_r <= cnt_r - CW'(3);
    end else if (cmd.load_byte) begin
      rd_idx_r <= rd_idx_r + CW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_stat) begin
      out_data_r <= 8'd0;
      out_bv_r   <= 1'b0;
      out_st_r   <= v_status;
      out_snd_r  <= v_sender;
      out_last_r <= 1'b1;
    end else if (cmd.load_byte) begin
      out_data_r <= rd_q_r;
      out_bv_r   <= 1'b1;
      out_st_r   <= ST_OK;
      out_snd_r  <= sender_r;
      out_last_r <= stat.rd_last;
    end
  end

  assign payload_byte = out_data_r;
  assign byte_valid   = out_bv_r;
  assign frame_status = out_st_r;
  assign sender_id    = out_snd_r;
  assign last         = out_last_r;

endmodule

// ===== sv/irdf_ctrl.sv =====
// Controller: handshakes, payload read-out sequencing and output valid.
module irdf_ctrl
  import irdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  irdf_stat_t  stat,
  output irdf_cmd_t   cmd,
  output irdf_state_t state
);

  irdf_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid && out_free && stat.close_burst) state_nxt = S_READ;
      end
      S_READ: state_nxt = S_LOAD;
      S_LOAD: begin
        if (out_free) state_nxt = stat.rd_last ? S_IDLE : S_READ;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_tready     = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        in_tready     = out_free;
        cmd.accept    = in_tvalid && out_free;
        cmd.load_stat = in_tvalid && out_free && stat.close_stat;
      end
      S_READ: cmd.rd_en = 1'b1;
      S_LOAD: cmd.load_byte = out_free;
      default: ;
    endcase
    if (cmd.load_stat || cmd.load_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign state      = state_r;

endmodule

// ===== sv/ir_packet_deframer_xor_check.sv =====
// A status item is valid the cycle after the end token transfer. A payload frame is read
// out one byte at a time: each byte is read from the store, then loaded into the output register when it is free.
// The input takes one link byte per cycle between frames while the output register is free;
// during a payload read-out the input is held off until the last payload byte is loaded.
// Reset clears the in-frame flag, overrun flag, byte count, controller state and output valid,
// and sets expected sender 75, any-sender off; the frame store, checksum and sender are not cleared.
module ir_packet_deframer_xor_check
  import irdf_pkg::*;
#(
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [15:8] sender_id
  output logic [2:0]  out_tuser,  // [0] byte_valid, [2:1] frame_status
  output logic        out_tlast,
  // Configuration writes
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  irdf_cmd_t   cmd;
  irdf_stat_t  stat;
  irdf_state_t state;
  logic [7:0]  payload_byte;
  logic        byte_valid;
  logic [1:0]  frame_status;
  logic [7:0]  sender_id;

  irdf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .state      (state)
  );

  irdf_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .rx_byte      (in_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .payload_byte (payload_byte),
    .byte_valid   (byte_valid),
    .frame_status (frame_status),
    .sender_id    (sender_id),
    .last         (out_tlast)
  );

  assign out_tdata = {sender_id, payload_byte};
  assign out_tuser = {frame_status, byte_valid};

  // Input is held off during a payload read-out
  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state != S_IDLE) |-> !in_tready)
    else $error("input ready during payload read-out");

  // A status item is always the final item of its frame
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> out_tlast)
    else $error("status item without last");

  // Payload bytes only come from frames that checked good
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] == ST_OK))
    else $error("payload byte with failing status");

  // A read is always followed by the load state for its byte
  a_read_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state == S_READ) |=> (state == S_LOAD))
    else $error("read not followed by load");

endmodule
